@@ sv/dbss_pkg.sv @@
// Shared types and constants for the detection box score sort block.
package dbss_pkg;

	localparam int MAX_BOXES_DEF = 64;
	localparam int COORD_W       = 12;
	localparam int SCORE_W       = 32;

	// One stored detection box
	typedef struct packed {
		logic [COORD_W-1:0]        x;
		logic [COORD_W-1:0]        y;
		logic signed [SCORE_W-1:0] score;
	} box_t;

	// Per-cycle command broadcast to every cell of the chain
	typedef struct packed {
		logic ins;    // insert the new box in order
		logic shift;  // move every entry one cell toward the head
	} cell_ctl_t;

	typedef enum logic {
		MODE_FILL,
		MODE_DRAIN
	} mode_t;

endpackage

@@ sv/detection_box_score_sort.sv @@
// Detection box score sort: a chain of cells that keeps boxes ordered by score.
//
// Input channel (box_x, box_y, box_score, last_box; in_valid/in_ready) takes
// one box per cycle while the block is filling. Each box is inserted into a
// chain of MAX_BOXES cells, highest score at the head; equal scores keep
// arrival order. When the chain is full, the lowest box (or the new one if it
// ranks lowest) is dropped and boxes_dropped is raised until the run drains.
// A transfer with last_box set inserts that box and starts the drain: the
// first result is offered the next cycle, then one result per cycle from the
// chain head while out_ready is high, the last one marked out_last. No input
// is taken during the drain. A stalled receiver simply holds the head cell
// and the chain in place. Reset empties the chain and clears the drop flag;
// no clearing pass needed.
module detection_box_score_sort #(
	parameter int MAX_BOXES = dbss_pkg::MAX_BOXES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [dbss_pkg::COORD_W-1:0]         box_x,
	input  logic [dbss_pkg::COORD_W-1:0]         box_y,
	input  logic signed [dbss_pkg::SCORE_W-1:0]  box_score,
	input  logic                                 last_box,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [dbss_pkg::COORD_W-1:0]         out_x,
	output logic [dbss_pkg::COORD_W-1:0]         out_y,
	output logic signed [dbss_pkg::SCORE_W-1:0]  out_score,
	output logic                                 out_last,
	output logic                                 boxes_dropped
);

	dbss_pkg::mode_t     mode_q;
	dbss_pkg::mode_t     mode_next;
	dbss_pkg::cell_ctl_t ctl;
	dbss_pkg::box_t      new_box;
	logic                drop_q;
	logic                in_xfer;
	logic                out_xfer;

	logic                cell_less  [MAX_BOXES];
	logic                cell_valid [MAX_BOXES];
	dbss_pkg::box_t      cell_box   [MAX_BOXES];

	assign new_box.x     = box_x;
	assign new_box.y     = box_y;
	assign new_box.score = box_score;

	// Cell chain
	for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
		logic           p_less;
		logic           p_valid;
		dbss_pkg::box_t p_box;
		logic           n_valid;
		dbss_pkg::box_t n_box;

		if (i == 0) begin : g_head
			assign p_less  = 1'b0;
			assign p_valid = 1'b0;
			assign p_box   = new_box;
		end else begin : g_mid
			assign p_less  = cell_less[i-1];
			assign p_valid = cell_valid[i-1];
			assign p_box   = cell_box[i-1];
		end

		if (i == MAX_BOXES - 1) begin : g_tail
			assign n_valid = 1'b0;
			assign n_box   = cell_box[i];
		end else begin : g_body
			assign n_valid = cell_valid[i+1];
			assign n_box   = cell_box[i+1];
		end

		dbss_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.new_box    (new_box),
			.prev_less  (p_less),
			.prev_valid (p_valid),
			.prev_box   (p_box),
			.next_valid (n_valid),
			.next_box   (n_box),
			.less       (cell_less[i]),
			.valid      (cell_valid[i]),
			.box        (cell_box[i])
		);
	end

	// Mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= dbss_pkg::MODE_FILL;
		end else begin
			mode_q <= mode_next;
		end
	end

	// Next mode
	always_comb begin
		mode_next = mode_q;
		unique case (mode_q)
			dbss_pkg::MODE_FILL: begin
				if (in_xfer && last_box) begin
					mode_next = dbss_pkg::MODE_DRAIN;
				end
			end
			dbss_pkg::MODE_DRAIN: begin
				if (out_xfer && !cell_valid[1]) begin
					mode_next = dbss_pkg::MODE_FILL;
				end
			end
			default: mode_next = dbss_pkg::MODE_FILL;
		endcase
	end

	// Handshake and chain commands
	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (mode_q)
			dbss_pkg::MODE_FILL:  in_ready  = 1'b1;
			dbss_pkg::MODE_DRAIN: out_valid = 1'b1;
			default: ;
		endcase
		in_xfer   = in_valid && in_ready;
		out_xfer  = out_valid && out_ready;
		ctl.ins   = in_xfer;
		ctl.shift = out_xfer;
	end

	// Drop flag: set on any insert into a full chain, cleared after the run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_q <= 1'b0;
		end else if (in_xfer && cell_valid[MAX_BOXES-1]) begin
			drop_q <= 1'b1;
		end else if (out_xfer && !cell_valid[1]) begin
			drop_q <= 1'b0;
		end
	end

	// Results come straight from the head cell
	assign out_x         = cell_box[0].x;
	assign out_y         = cell_box[0].y;
	assign out_score     = cell_box[0].score;
	assign out_last      = !cell_valid[1];
	assign boxes_dropped = drop_q;

endmodule

@@ sv/dbss_cell.sv @@
// One cell of the sorted insertion chain: holds a box and its valid bit.
module dbss_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  dbss_pkg::cell_ctl_t ctl,
	input  dbss_pkg::box_t    new_box,
	input  logic              prev_less,   // upstream cell ranks below the new box
	input  logic              prev_valid,
	input  dbss_pkg::box_t    prev_box,
	input  logic              next_valid,
	input  dbss_pkg::box_t    next_box,
	output logic              less,
	output logic              valid,
	output dbss_pkg::box_t    box
);

	logic           valid_q;
	dbss_pkg::box_t box_q;

	// Stored box ranks below the new one (empty cells count as lower);
	// ties keep the stored box ahead
	assign less  = !valid_q || (box_q.score < new_box.score);
	assign valid = valid_q;
	assign box   = box_q;

	// Valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= next_valid;
		end else if (ctl.ins && less) begin
			valid_q <= prev_less ? prev_valid : 1'b1;
		end
	end

	// Payload: new box lands at the first lower cell, the rest move down
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			box_q <= next_box;
		end else if (ctl.ins && less) begin
			box_q <= prev_less ? prev_box : new_box;
		end
	end

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the detection box score sort block.
module tb_top;

	localparam int MAX_BOXES   = dbss_pkg::MAX_BOXES_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 32;
	localparam int PRINT_CAP   = 30;
	localparam logic signed [dbss_pkg::SCORE_W-1:0] SCORE_MIN = 32'sh8000_0000;
	localparam logic signed [dbss_pkg::SCORE_W-1:0] SCORE_MAX = 32'sh7FFF_FFFF;

	// One emitted box as the block should present it
	typedef struct {
		logic [dbss_pkg::COORD_W-1:0]        x;
		logic [dbss_pkg::COORD_W-1:0]        y;
		logic signed [dbss_pkg::SCORE_W-1:0] score;
		logic                                last;
		logic                                dropped;
	} emit_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [dbss_pkg::COORD_W-1:0] box_x = '0;
	logic [dbss_pkg::COORD_W-1:0] box_y = '0;
	logic signed [dbss_pkg::SCORE_W-1:0] box_score = '0;
	logic last_box = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [dbss_pkg::COORD_W-1:0] out_x;
	logic [dbss_pkg::COORD_W-1:0] out_y;
	logic signed [dbss_pkg::SCORE_W-1:0] out_score;
	logic out_last;
	logic boxes_dropped;

	// Shadow of the sorted store and the expected drain order
	dbss_pkg::box_t ranked_boxes[$];
	bit    drop_seen;
	emit_t pending_emits[$];

	int err_count;
	int cycle_count;
	int sets_sent;
	int boxes_sent;
	int emits_checked;
	int drop_sets;
	bit src_gaps_on = 1'b1;
	bit sink_stall_on = 1'b1;
	int sink_hold;

	detection_box_score_sort #(.MAX_BOXES(MAX_BOXES)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.box_x(box_x),
		.box_y(box_y),
		.box_score(box_score),
		.last_box(last_box),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_x(out_x),
		.out_y(out_y),
		.out_score(out_score),
		.out_last(out_last),
		.boxes_dropped(boxes_dropped)
	);

	// Clock, period 8
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		if (err_count < PRINT_CAP)
			$display("MISMATCH @%0d: %s", cycle_count, msg);
		err_count++;
	endtask

	// Idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Random coordinate over the full 12-bit range
	function automatic logic [dbss_pkg::COORD_W-1:0] pick_coord();
		return dbss_pkg::COORD_W'($urandom_range(0, 4095));
	endfunction

	// Score mixes: full range, tie-rich, corner values, small Q16.16 range
	function automatic logic signed [dbss_pkg::SCORE_W-1:0] pick_score(input int mix);
		logic signed [dbss_pkg::SCORE_W-1:0] s;
		case (mix)
			1: s = ($urandom_range(0, 4) - 2) <<< 16;
			2: begin
				case ($urandom_range(0, 4))
					0: s = SCORE_MIN;
					1: s = SCORE_MAX;
					2: s = 0;
					3: s = -1;
					default: s = 1;
				endcase
			end
			3: s = $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
			default: s = $urandom;
		endcase
		return s;
	endfunction

	// Insert one accepted box into the shadow store; on last, queue the drain
	task automatic rank_box(input dbss_pkg::box_t b, input bit is_last);
		int pos;
		emit_t e;
		pos = 0;
		while (pos < ranked_boxes.size() && $signed(ranked_boxes[pos].score) >= $signed(b.score))
			pos++;
		ranked_boxes.insert(pos, b);
		if (ranked_boxes.size() > MAX_BOXES) begin
			void'(ranked_boxes.pop_back());
			drop_seen = 1'b1;
		end
		if (is_last) begin
			for (int k = 0; k < ranked_boxes.size(); k++) begin
				e.x = ranked_boxes[k].x;
				e.y = ranked_boxes[k].y;
				e.score = ranked_boxes[k].score;
				e.last = (k == ranked_boxes.size() - 1);
				e.dropped = drop_seen;
				pending_emits.push_back(e);
			end
			if (drop_seen)
				drop_sets++;
			sets_sent++;
			ranked_boxes.delete();
			drop_seen = 1'b0;
		end
	endtask

	// Send one box and wait for its transfer, then maybe idle
	task automatic push_box(input logic [dbss_pkg::COORD_W-1:0] x,
			input logic [dbss_pkg::COORD_W-1:0] y,
			input logic signed [dbss_pkg::SCORE_W-1:0] s, input bit is_last);
		dbss_pkg::box_t b;
		int gap;
		in_valid <= 1'b1;
		box_x <= x;
		box_y <= y;
		box_score <= s;
		last_box <= is_last;
		do
			@(posedge clk);
		while (!in_ready);
		b.x = x;
		b.y = y;
		b.score = s;
		rank_box(b, is_last);
		boxes_sent++;
		gap = src_gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold the sender until the whole drain has been seen
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_emits.size() != 0)
			@(posedge clk);
	endtask

	task automatic push_random_set(input int n, input int mix);
		for (int i = 0; i < n; i++)
			push_box(pick_coord(), pick_coord(), pick_score(mix), i == n - 1);
	endtask

	// Coordinate and score corners, sign ordering, ties
	task automatic test_directed_sets();
		push_box(12'h000, 12'h000, SCORE_MIN, 1'b1);
		push_box(12'hFFF, 12'hFFF, SCORE_MAX, 1'b1);
		// signed compare across zero, Q16.16 units
		push_box(12'hAAA, 12'h555, 0, 1'b0);
		push_box(12'h555, 12'hAAA, -1, 1'b0);
		push_box(12'h001, 12'h800, 1, 1'b0);
		push_box(12'h800, 12'h001, SCORE_MAX, 1'b0);
		push_box(12'h7FF, 12'hF00, SCORE_MIN, 1'b0);
		push_box(12'h0F0, 12'h0FF, 32'sh0001_0000, 1'b0);
		push_box(12'hF0F, 12'h00F, 32'shFFFF_0000, 1'b0);
		push_box(12'h123, 12'h321, 0, 1'b1);
		// equal scores keep arrival order, last box included
		for (int i = 0; i < 4; i++)
			push_box(12'(i + 1), 12'(4 - i), 32'sh0005_0000, 1'b0);
		push_box(12'h005, 12'h000, 32'sh0005_0000, 1'b1);
		// rising scores, each new one goes to the head
		push_box(12'h010, 12'h020, -32'sd3, 1'b0);
		push_box(12'h011, 12'h021, 32'sd7, 1'b0);
		push_box(12'h012, 12'h022, 32'sd9, 1'b1);
		wait_drained();
	endtask

	// Full store: exact fit, drop of lowest, drop of a tied newcomer, long run
	task automatic test_capacity_overflow();
		push_random_set(MAX_BOXES, 0);
		wait_drained();
		for (int i = 0; i < MAX_BOXES; i++)
			push_box(pick_coord(), pick_coord(), pick_score(3), 1'b0);
		push_box(12'hFFF, 12'h000, SCORE_MAX, 1'b1);
		wait_drained();
		push_box(12'hABC, 12'hCBA, -32'sd100, 1'b0);
		for (int i = 1; i < MAX_BOXES; i++)
			push_box(pick_coord(), pick_coord(), $urandom_range(0, 1000) - 100, 1'b0);
		push_box(12'h000, 12'hFFF, -32'sd100, 1'b1);
		wait_drained();
		push_random_set(MAX_BOXES + 16, 1);
		wait_drained();
	endtask

	// Random sets, mostly small, with stretches of full rate on either side
	task automatic test_random_sets();
		int sent;
		int n;
		int r;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 80)
				n = $urandom_range(1, 10);
			else if (r < 94)
				n = $urandom_range(11, 50);
			else
				n = $urandom_range(MAX_BOXES - 1, MAX_BOXES + 8);
			// keep the total near the planned item count
			if (n > RANDOM_ITEMS - sent)
				n = RANDOM_ITEMS - sent;
			push_random_set(n, $urandom_range(0, 3));
			sent += n;
			if ($urandom_range(0, 5) == 0)
				src_gaps_on = !src_gaps_on;
			if ($urandom_range(0, 5) == 0)
				sink_stall_on = !sink_stall_on;
			if ($urandom_range(0, 7) == 0)
				wait_drained();
		end
		src_gaps_on = 1'b1;
		sink_stall_on = 1'b1;
		wait_drained();
	endtask

	// Receiver: ready runs and stalls of random length
	always @(posedge clk) begin
		if (sink_hold > 0)
			sink_hold <= sink_hold - 1;
		else if (!sink_stall_on)
			out_ready <= 1'b1;
		else if (out_ready) begin
			out_ready <= 1'b0;
			sink_hold <= pick_gap();
		end else begin
			out_ready <= 1'b1;
			sink_hold <= $urandom_range(0, 6);
		end
	end

	// Compare each result transfer with the oldest expected box
	always @(posedge clk) begin
		emit_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_emits.size() == 0)
				report_mismatch($sformatf("unexpected result x=%0d y=%0d score=%0d",
					out_x, out_y, out_score));
			else begin
				want = pending_emits.pop_front();
				emits_checked++;
				if (out_x !== want.x)
					report_mismatch($sformatf("out_x %0d, want %0d", out_x, want.x));
				if (out_y !== want.y)
					report_mismatch($sformatf("out_y %0d, want %0d", out_y, want.y));
				if (out_score !== want.score)
					report_mismatch($sformatf("out_score %0d, want %0d",
						out_score, want.score));
				if (out_last !== want.last)
					report_mismatch($sformatf("out_last %b, want %b", out_last, want.last));
				if (boxes_dropped !== want.dropped)
					report_mismatch($sformatf("boxes_dropped %b, want %b",
						boxes_dropped, want.dropped));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_sets();
		test_capacity_overflow();
		test_random_sets();
		repeat (100) @(posedge clk);
		if (pending_emits.size() != 0)
			report_mismatch($sformatf("%0d results never came", pending_emits.size()));
		$display("Sent %0d boxes in %0d sets, %0d of them over capacity;",
			boxes_sent, sets_sent, drop_sets);
		$display("checked %0d sorted results, %0d mismatches.", emits_checked, err_count);
		if (err_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
